>>> src/assert_macros.svh
// Assertion helpers included by pixel_to_hex_axial_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/p2h_pkg.sv
// ----------------------------------------------------------------------------
// p2h_pkg
// Types, constants and helpers for the pixel to hex axial block.
// ----------------------------------------------------------------------------
package p2h_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DW            = 32;  // divisor / remainder width
    localparam int QW            = 63;  // numerator and quotient magnitude width
    localparam int OW            = 24;  // output width
    localparam int NW            = 35;  // rounded coordinate width

    // hex basis, unsigned Q0.32
    localparam logic [31:0] K_INV_SQRT3  = 32'd2479700524;
    localparam logic [31:0] K_THIRD      = 32'd1431655765;
    localparam logic [31:0] K_TWO_THIRDS = 32'd2863311531;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
        logic          neg;
    } t_div_lane;

    typedef struct packed {
        logic      valid;
        t_div_lane lane_q;
        t_div_lane lane_r;
    } t_div_cell;

    function automatic logic [OW-1:0] sat_out(input logic signed [NW+1:0] v);
        logic signed [NW+1:0] hi;
        logic signed [NW+1:0] lo;
        hi = (NW+2)'(signed'(24'sh7FFFFF));
        lo = -(NW+2)'(signed'(25'sh0800000));
        if (v > hi)      sat_out = 24'h7FFFFF;
        else if (v < lo) sat_out = 24'h800000;
        else             sat_out = v[OW-1:0];
    endfunction

endpackage

>>> src/pixel_to_hex_axial_top.sv
// ----------------------------------------------------------------------------
// pixel_to_hex_axial_top
// Maps a Q16.16 plane position to its pointy-top hex cell in axial q, r.
// ----------------------------------------------------------------------------
// Takes one item per clock while o_ready is high and gives one result per
// item. Its registered stages in order: the basis multipliers, 63 division
// cells (one quotient bit of each coordinate per cell, divisor is the hex
// size), the signed cube coordinates, cube rounding and the output register.
// An output register plus a one-entry skid buffer let input keep flowing
// while a result waits; o_ready drops only while the skid entry is occupied.
// The hex size may only be written while no item is in flight; 0 acts as 1.
module pixel_to_hex_axial_top
    import p2h_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [OW-1:0] o_hex_q,
    output logic signed [OW-1:0] o_hex_r,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_hex_size
);

    `include "assert_macros.svh"

    logic [31:0]        r_hex_size;
    logic [DW-1:0]      div_d;
    logic               adv;

    logic               r_v0;
    logic signed [63:0] r_p1, r_p2, r_p3;
    logic signed [64:0] n_p1, n_p2, n_p3;

    t_div_cell          w_chain [0:QW];

    logic signed [63:0] qn;
    logic [63:0]        qmag, rmag;

    logic signed [63:0] qf, rf;
    logic signed [64:0] qf_x, rf_x, sf_x;
    logic               r_vf;
    logic signed [64:0] r_qf, r_rf, r_sf;
    logic signed [NW-1:0] w_q, w_r, w_s;
    logic [31:0]        w_eq, w_er, w_es;

    logic               r_vr;
    logic signed [NW-1:0] r_q, r_r, r_s;
    logic [31:0]        r_eq, r_er, r_es;
    logic signed [NW+1:0] sel_q, sel_r;
    logic [OW-1:0]      res_q, res_r;

    logic               r_o_valid, r_sk_valid;
    logic [OW-1:0]      r_o_q, r_o_r, r_sk_q, r_sk_r;

    // configuration
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_size <= 32'(64'd1 << FRAC_BITS);
        end else if (i_cfg_valid) begin
            r_hex_size <= i_cfg_hex_size;
        end
    end
    assign div_d = (r_hex_size == 32'd0) ? 32'd1 : r_hex_size;

    assign adv     = !r_sk_valid;
    assign o_ready = adv;

    // basis multiply
    assign n_p1 = i_pos_x * $signed({1'b0, K_INV_SQRT3});
    assign n_p2 = i_pos_y * $signed({1'b0, K_THIRD});
    assign n_p3 = i_pos_y * $signed({1'b0, K_TWO_THIRDS});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1 <= n_p1[63:0];
            r_p2 <= n_p2[63:0];
            r_p3 <= n_p3[63:0];
        end
    end

    // division chain entry
    assign qn   = r_p1 - r_p2;
    assign qmag = qn[63] ? 64'(-qn) : qn;
    assign rmag = r_p3[63] ? 64'(-r_p3) : r_p3;

    assign w_chain[0] = '{
        valid:  r_v0,
        lane_q: '{rem: '0, num: qmag[QW-1:0], quo: '0, neg: qn[63]},
        lane_r: '{rem: '0, num: rmag[QW-1:0], quo: '0, neg: r_p3[63]}
    };

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        p2h_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_div  (div_d),
            .i_cell (w_chain[gi]),
            .o_cell (w_chain[gi+1])
        );
    end

    // cube coordinates
    assign qf = w_chain[QW].lane_q.neg ? -$signed({1'b0, w_chain[QW].lane_q.quo})
                                       :  $signed({1'b0, w_chain[QW].lane_q.quo});
    assign rf = w_chain[QW].lane_r.neg ? -$signed({1'b0, w_chain[QW].lane_r.quo})
                                       :  $signed({1'b0, w_chain[QW].lane_r.quo});
    assign qf_x = 65'(qf);
    assign rf_x = 65'(rf);
    assign sf_x = -qf_x - rf_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (adv) begin
            r_vf <= w_chain[QW].valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qf <= qf_x;
            r_rf <= rf_x;
            r_sf <= sf_x;
        end
    end

    // rounding
    p2h_round u_rnd_q (.i_val(r_qf), .o_int(w_q), .o_err(w_eq));
    p2h_round u_rnd_r (.i_val(r_rf), .o_int(w_r), .o_err(w_er));
    p2h_round u_rnd_s (.i_val(r_sf), .o_int(w_s), .o_err(w_es));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (adv) begin
            r_vr <= r_vf;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q  <= w_q;
            r_r  <= w_r;
            r_s  <= w_s;
            r_eq <= w_eq;
            r_er <= w_er;
            r_es <= w_es;
        end
    end

    // rebuild the coordinate with the largest rounding error
    always_comb begin
        sel_q = (NW+2)'(r_q);
        sel_r = (NW+2)'(r_r);
        priority if (r_eq > r_er && r_eq > r_es) begin
            sel_q = -(NW+2)'(r_r) - (NW+2)'(r_s);
        end else if (r_er > r_es) begin
            sel_r = -(NW+2)'(r_q) - (NW+2)'(r_s);
        end else begin
            sel_q = (NW+2)'(r_q);
        end
    end
    assign res_q = sat_out(sel_q);
    assign res_r = sat_out(sel_r);

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_o_valid || i_ready) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_o_valid  <= r_vr;
            end
        end else if (r_vr) begin
            r_sk_valid <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_o_valid || i_ready) begin
            if (r_sk_valid) begin
                r_o_q <= r_sk_q;
                r_o_r <= r_sk_r;
            end else begin
                r_o_q <= res_q;
                r_o_r <= res_r;
            end
        end else if (adv && r_vr) begin
            r_sk_q <= res_q;
            r_sk_r <= res_r;
        end
    end

    assign o_valid = r_o_valid;
    assign o_hex_q = r_o_q;
    assign o_hex_r = r_o_r;

    `ASSERT_CLK(a_skid_needs_out, r_sk_valid |-> r_o_valid)
    `ASSERT_CLK(a_div_nonzero, div_d != 32'd0)
    `ASSERT_NEXT(a_skid_drains, r_sk_valid && i_ready, !r_sk_valid)

endmodule

>>> src/p2h_div_cell.sv
// ----------------------------------------------------------------------------
// p2h_div_cell
// One restoring division step for both coordinates: one quotient bit each.
// ----------------------------------------------------------------------------
module p2h_div_cell
    import p2h_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [DW-1:0] i_div,
    input  t_div_cell     i_cell,
    output t_div_cell     o_cell
);

    t_div_cell n_cell;
    logic      r_valid;
    t_div_lane r_lane_q;
    t_div_lane r_lane_r;

    function automatic t_div_lane step(input t_div_lane l, input logic [DW-1:0] d);
        t_div_lane     o;
        logic [DW:0]   t;
        logic          ge;
        t  = {l.rem, l.num[QW-1]};
        ge = (t >= {1'b0, d});
        o.rem = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
        o.num = {l.num[QW-2:0], 1'b0};
        o.quo = {l.quo[QW-2:0], ge};
        o.neg = l.neg;
        return o;
    endfunction

    always_comb begin
        n_cell        = i_cell;
        n_cell.lane_q = step(i_cell.lane_q, i_div);
        n_cell.lane_r = step(i_cell.lane_r, i_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane_q <= n_cell.lane_q;
            r_lane_r <= n_cell.lane_r;
        end
    end

    assign o_cell = {r_valid, r_lane_q, r_lane_r};

endmodule

>>> src/p2h_round.sv
// ----------------------------------------------------------------------------
// p2h_round
// Rounds a signed Q.32 value half away from zero and reports the error.
// ----------------------------------------------------------------------------
module p2h_round
    import p2h_pkg::*;
(
    input  logic signed [64:0]   i_val,
    output logic signed [NW-1:0] o_int,
    output logic [31:0]          o_err
);

    logic          neg;
    logic [64:0]   mag;
    logic [65:0]   sum;
    logic [33:0]   k;
    logic [65:0]   back;
    logic [65:0]   diff;

    always_comb begin
        neg  = i_val[64];
        mag  = neg ? 65'(-i_val) : i_val;
        sum  = {1'b0, mag} + 66'h80000000;
        k    = sum[65:32];
        back = {k, 32'h0};
        diff = (back > {1'b0, mag}) ? back - {1'b0, mag} : {1'b0, mag} - back;
        o_err = diff[31:0];
        o_int = neg ? -$signed({1'b0, k}) : $signed({1'b0, k});
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_to_hex_axial_top: random and directed plane
// positions over several hex sizes, results checked against a local
// cube-rounding predictor, with random idling on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import p2h_pkg::*;
();

    localparam int LATENCY = 67;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_pos;

    typedef struct {
        logic signed [23:0] q;
        logic signed [23:0] r;
    } t_cell;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_hex_q;
    logic signed [23:0] o_hex_r;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [31:0] i_cfg_hex_size = '0;

    t_pos pending_pos[$];
    t_cell expected_cells[$];
    logic [31:0] hex_size_model;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int in_flight = 0;      // items handed to the driver but not yet taken

    always #5 i_clk = ~i_clk;

    pixel_to_hex_axial_top dut (.*);

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Round a signed Q.32 value half away from zero; also return the error.
    function automatic logic signed [63:0] round_cube(input logic signed [63:0] v,
                                                      output logic [63:0] err);
        logic [63:0] mag;
        logic [63:0] k;
        logic [63:0] back;
        mag = abs64(v);
        k = (mag + 64'h8000_0000) >> 32;
        back = k << 32;
        err = back > mag ? back - mag : mag - back;
        return v < 0 ? -$signed(k) : $signed(k);
    endfunction

    function automatic logic signed [63:0] div_toward_zero(input logic signed [63:0] n,
                                                           input logic [63:0] d);
        logic [63:0] quo;
        quo = abs64(n) / d;
        return n < 0 ? -$signed(quo) : $signed(quo);
    endfunction

    function automatic logic signed [23:0] clamp24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic t_cell locate_hex(input t_pos p);
        logic signed [63:0] x, y, qn, rn, qf, rf, sf, q, r, s;
        logic [63:0] d, eq, er, es;
        t_cell c;
        x = p.x;
        y = p.y;
        d = hex_size_model == 0 ? 64'd1 : 64'(hex_size_model);
        qn = x * $signed(64'(K_INV_SQRT3)) - y * $signed(64'(K_THIRD));
        rn = y * $signed(64'(K_TWO_THIRDS));
        qf = div_toward_zero(qn, d);
        rf = div_toward_zero(rn, d);
        sf = -qf - rf;
        q = round_cube(qf, eq);
        r = round_cube(rf, er);
        s = round_cube(sf, es);
        if (eq > er && eq > es) q = -r - s;
        else if (er > es) r = -q - s;
        c.q = clamp24(q);
        c.r = clamp24(r);
        return c;
    endfunction

    // Driver: one nonblocking update of i_valid per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_cells.push_back(locate_hex('{i_pos_x, i_pos_y}));
                in_flight--;
            end
            if (!(i_valid && !o_ready)) begin
                if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pos p;
                    p = pending_pos.pop_front();
                    i_pos_x <= p.x;
                    i_pos_y <= p.y;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected result q=%0d r=%0d", o_hex_q, o_hex_r);
                    errors++;
                end else begin
                    t_cell e;
                    e = expected_cells.pop_front();
                    if (o_hex_q !== e.q) begin
                        $error("hex_q expected %0d actual %0d", e.q, o_hex_q);
                        errors++;
                    end
                    if (o_hex_r !== e.r) begin
                        $error("hex_r expected %0d actual %0d", e.r, o_hex_r);
                        errors++;
                    end
                end
            end
            i_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic queue_pos(input logic [31:0] x, input logic [31:0] y);
        pending_pos.push_back('{x, y});
        in_flight++;
    endtask

    task automatic drain();
        wait (in_flight == 0 && !i_valid);
        wait (expected_cells.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_hex_size(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_hex_size <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hex_size_model = v;
    endtask

    function automatic logic [31:0] rand_coord(input logic [31:0] cs);
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(200)) - 100) * cs
                      + 32'($urandom_range(65535) - 32768);
            2: return {{8{$urandom_range(1) == 1}}, 24'($urandom())};
            3: return 32'($signed($urandom_range(40)) - 20) * 32'd65536 + 32'h8000;
            default: return {$urandom_range(1) == 1 ? 2'b10 : 2'b01, 30'($urandom())};
        endcase
    endfunction

    // each phase runs out before the next one sets its own idling
    task automatic random_batch(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            queue_pos(rand_coord(hex_size_model), rand_coord(hex_size_model));
        drain();
    endtask

    initial begin
        logic [31:0] sizes[6];
        logic [31:0] extremes[6];
        sizes = '{32'd65536, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3 << 15, 32'd400000};
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000};
        hex_size_model = 32'd65536;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // corners of the input range at reset hex size
        foreach (extremes[a])
            foreach (extremes[b])
                if (a < 4 || b < 4) queue_pos(extremes[a], extremes[b]);
        drain();
        foreach (sizes[k]) begin
            write_hex_size(sizes[k]);
            queue_pos(32'h8000_0000, 32'h8000_0000);
            queue_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
            random_batch(25, 0, 0);
            random_batch(25, 75, 0);
            random_batch(25, 0, 75);
            random_batch(25, 21, 21);
            drain();    // sender holds off until every result is in
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/p2h_pkg.sv
src/p2h_div_cell.sv
src/p2h_round.sv
src/pixel_to_hex_axial_top.sv
tb/sv/testbench.sv
